/* rtl/core/ik_pkg.sv */
`default_nettype none
package ik_pkg;

	localparam int POS_FRAC_BITS = 4;
	localparam int CORDIC_STEPS  = 24;
	localparam int SQRT_STEPS    = 26;
	localparam int SQRT_IN_W     = 2 * SQRT_STEPS;
	localparam int POS_SHIFT     = 16 - POS_FRAC_BITS;

	localparam logic signed [31:0] HALF_TURN  = 32'sd117964800;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BASE_X = 2'd0,
		REG_BASE_Y = 2'd1,
		REG_LINK   = 2'd2
	} ik_reg_t;

	// Decoded command as it sits in the queue between front and back.
	typedef struct packed {
		logic               op;
		logic        [13:0] target_x;
		logic        [13:0] target_y;
		logic signed [12:0] target_phi;
		logic signed [12:0] current_joint1;
		logic signed [12:0] current_joint2;
		logic signed [12:0] current_joint3;
		logic signed [10:0] phi_fold;
		logic               phi_neg;
	} ik_job_t;

	typedef struct packed {
		logic push;
		logic full;
	} ik_q_wr_t;

	function automatic logic signed [31:0] atan_tab(input logic [4:0] i);
		logic signed [31:0] v;
		unique case (i)
			5'd0:  v = 32'sd29491200;
			5'd1:  v = 32'sd17409672;
			5'd2:  v = 32'sd9198793;
			5'd3:  v = 32'sd4669451;
			5'd4:  v = 32'sd2343786;
			5'd5:  v = 32'sd1173036;
			5'd6:  v = 32'sd586661;
			5'd7:  v = 32'sd293348;
			5'd8:  v = 32'sd146676;
			5'd9:  v = 32'sd73339;
			5'd10: v = 32'sd36669;
			5'd11: v = 32'sd18335;
			5'd12: v = 32'sd9167;
			5'd13: v = 32'sd4584;
			5'd14: v = 32'sd2292;
			5'd15: v = 32'sd1146;
			5'd16: v = 32'sd573;
			5'd17: v = 32'sd286;
			5'd18: v = 32'sd143;
			5'd19: v = 32'sd72;
			5'd20: v = 32'sd36;
			5'd21: v = 32'sd18;
			5'd22: v = 32'sd9;
			5'd23: v = 32'sd4;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// Round half up to whole tenths: floor((v + 2^15) / 2^16).
	function automatic logic [15:0] round_tenths(input logic signed [31:0] v);
		logic signed [31:0] t;
		t = v + 32'sd32768;
		return t[31:16];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/ik_cmd_if.sv */
`default_nettype none
interface ik_cmd_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic        [13:0] target_x;
	logic        [13:0] target_y;
	logic signed [12:0] target_phi;
	logic signed [12:0] current_joint1;
	logic signed [12:0] current_joint2;
	logic signed [12:0] current_joint3;
	modport source(output valid, op, target_x, target_y, target_phi,
		current_joint1, current_joint2, current_joint3, input ready);
	modport sink(input valid, op, target_x, target_y, target_phi,
		current_joint1, current_joint2, current_joint3, output ready);
endinterface
`default_nettype wire

/* rtl/core/ik_res_if.sv */
`default_nettype none
interface ik_res_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] joint1_angle;
	logic signed [12:0] joint2_angle;
	logic signed [14:0] joint3_angle;
	logic               unreachable;
	modport source(output valid, joint1_angle, joint2_angle, joint3_angle,
		unreachable, input ready);
	modport sink(input valid, joint1_angle, joint2_angle, joint3_angle,
		unreachable, output ready);
endinterface
`default_nettype wire

/* rtl/core/ik_cfg_if.sv */
`default_nettype none
interface ik_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ik_front.sv */
`default_nettype none
module ik_front (
	ik_cmd_if.sink          cmd,
	input  logic            full,
	output logic            push,
	output ik_pkg::ik_job_t job
);
	import ik_pkg::*;

	logic signed [13:0] p_wrap;
	logic signed [13:0] p_fold;

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	// Wrap into [-1800,1800), then fold into [-900,900] with the vector negated.
	always_comb begin
		priority if (cmd.target_phi >= 13'sd1800) begin
			p_wrap = 14'(cmd.target_phi) - 14'sd3600;
		end else if (cmd.target_phi < -13'sd1800) begin
			p_wrap = 14'(cmd.target_phi) + 14'sd3600;
		end else begin
			p_wrap = 14'(cmd.target_phi);
		end
		job.phi_neg = 1'b1;
		priority if (p_wrap > 14'sd900) begin
			p_fold = p_wrap - 14'sd1800;
		end else if (p_wrap < -14'sd900) begin
			p_fold = p_wrap + 14'sd1800;
		end else begin
			p_fold      = p_wrap;
			job.phi_neg = 1'b0;
		end
		job.op             = cmd.op;
		job.target_x       = cmd.target_x;
		job.target_y       = cmd.target_y;
		job.target_phi     = cmd.target_phi;
		job.current_joint1 = cmd.current_joint1;
		job.current_joint2 = cmd.current_joint2;
		job.current_joint3 = cmd.current_joint3;
		job.phi_fold       = p_fold[10:0];
	end
endmodule
`default_nettype wire

/* rtl/core/ik_queue.sv */
`default_nettype none
module ik_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ik_pkg::ik_job_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nempty,
	output ik_pkg::ik_job_t rdata
);
	import ik_pkg::*;

	ik_job_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full   = cnt_q == 2'd2;
	assign nempty = cnt_q != 2'd0;
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not advance");
endmodule
`default_nettype wire

/* rtl/core/ik_isqrt.sv */
`default_nettype none
module ik_isqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ik_pkg::SQRT_IN_W-1:0]       opnd,
	output logic                               busy,
	output logic [ik_pkg::SQRT_STEPS-1:0]      root
);
	import ik_pkg::*;

	logic [SQRT_IN_W-1:0]  a_q;
	logic [SQRT_STEPS+1:0] rem_q;
	logic [SQRT_STEPS-1:0] q_q;
	logic [4:0]            cnt_q;
	logic                  busy_q;
	logic [SQRT_STEPS+3:0] remn;
	logic [SQRT_STEPS+3:0] trial;
	logic                  take;

	assign busy  = busy_q;
	assign root  = q_q;
	assign remn  = {rem_q, a_q[SQRT_IN_W-1 -: 2]};
	assign trial = {2'b00, q_q, 2'b01};
	assign take  = remn >= trial;

	// One result bit per cycle, restoring form.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= opnd;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[SQRT_IN_W-3:0], 2'b00};
			rem_q <= take ? (SQRT_STEPS+2)'(remn - trial) : (SQRT_STEPS+2)'(remn);
			q_q   <= {q_q[SQRT_STEPS-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(SQRT_STEPS - 1)) busy_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/ik_back.sv */
`default_nettype none
module ik_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            nempty,
	input  ik_pkg::ik_job_t job,
	output logic            pop,
	input  logic [9:0]      base_x,
	input  logic [9:0]      base_y,
	input  logic [7:0]      link_len,
	ik_res_if.source        res
);
	import ik_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ROT   = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_WRIST = 4'd3;
	localparam logic [3:0] ST_SQ    = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_VEC   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]         state_q;
	logic [4:0]         cnt_q;
	ik_job_t            job_q;
	logic signed [33:0] rx_q, ry_q;
	logic signed [31:0] rz_q;
	logic signed [42:0] lc_q, ls_q;
	logic signed [29:0] xw_q, yw_q;
	logic        [59:0] xx_q, yy_q;
	logic               unr_q, zero_q;
	logic signed [31:0] ax_q, ay_q, az_q;
	logic signed [31:0] bx_q, by_q, bz_q;
	logic               outv_q;
	logic signed [12:0] j1_q, j2_q;
	logic signed [14:0] j3_q;
	logic               unro_q;

	logic signed [33:0] cn, sn;
	logic signed [42:0] lcr, lsr;
	logic signed [43:0] xw_w, yw_w;
	logic        [60:0] d2;
	logic        [49:0] lim;
	logic        [15:0] ll;
	logic               sq_start;
	logic [SQRT_IN_W-1:0] r_opnd, h_opnd;
	logic               r_busy, h_busy;
	logic [SQRT_STEPS-1:0] r_root, h_root;
	logic signed [31:0] at;
	logic signed [31:0] a1, a2, a3;
	logic               fin_go;

	assign pop    = state_q == ST_IDLE && nempty;
	assign at     = atan_tab(cnt_q);
	assign fin_go = state_q == ST_FIN && (!outv_q || res.ready);

	assign cn  = job_q.phi_neg ? -rx_q : rx_q;
	assign sn  = job_q.phi_neg ? -ry_q : ry_q;
	assign lcr = (lc_q + 43'sd8192) >>> 14;
	assign lsr = (ls_q + 43'sd8192) >>> 14;
	assign xw_w = $signed({18'd0, job_q.target_x, POS_SHIFT'(0)})
		- 44'(lcr) - $signed({18'd0, base_x, 16'd0});
	assign yw_w = $signed({18'd0, job_q.target_y, POS_SHIFT'(0)})
		- 44'(lsr) - $signed({18'd0, base_y, 16'd0});
	assign d2  = 61'(xx_q) + 61'(yy_q);
	assign ll  = link_len * link_len;
	assign lim = {ll, 2'b00, 32'd0};

	assign sq_start = state_q == ST_SUM && !(link_len == 8'd0 || d2 > 61'(lim))
		&& d2 != 61'd0;
	assign r_opnd = d2[SQRT_IN_W-1:0];
	assign h_opnd = SQRT_IN_W'(61'(lim) - d2);

	ik_isqrt u_sqrt_r (.clk(clk), .arst_n(arst_n), .start(sq_start), .opnd(r_opnd),
		.busy(r_busy), .root(r_root));
	ik_isqrt u_sqrt_h (.clk(clk), .arst_n(arst_n), .start(sq_start), .opnd(h_opnd),
		.busy(h_busy), .root(h_root));

	always_comb begin
		if (zero_q) begin
			a1 = '0;
			a2 = job_q.op ? -HALF_TURN : HALF_TURN;
		end else if (job_q.op) begin
			a1 = bz_q + az_q;
			a2 = -(az_q <<< 1);
		end else begin
			a1 = bz_q - az_q;
			a2 = az_q <<< 1;
		end
		a3 = $signed({{3{job_q.target_phi[12]}}, job_q.target_phi, 16'd0}) - a1 - a2;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
				rx_q  <= CORDIC_GAIN;
				ry_q  <= '0;
				rz_q  <= $signed({{5{job.phi_fold[10]}}, job.phi_fold, 16'd0});
				unr_q  <= 1'b0;
				zero_q <= 1'b0;
			end
			ST_ROT: begin
				if (rz_q >= 0) begin
					rx_q <= rx_q - (ry_q >>> cnt_q);
					ry_q <= ry_q + (rx_q >>> cnt_q);
					rz_q <= rz_q - at;
				end else begin
					rx_q <= rx_q + (ry_q >>> cnt_q);
					ry_q <= ry_q - (rx_q >>> cnt_q);
					rz_q <= rz_q + at;
				end
			end
			ST_MUL: begin
				lc_q <= $signed({1'b0, link_len}) * cn;
				ls_q <= $signed({1'b0, link_len}) * sn;
			end
			ST_WRIST: begin
				xw_q <= xw_w[29:0];
				yw_q <= yw_w[29:0];
			end
			ST_SQ: begin
				xx_q <= 60'(xw_q * xw_q);
				yy_q <= 60'(yw_q * yw_q);
			end
			ST_SUM: begin
				// Prepare the wrist atan2: mirror a negative x into the right half.
				unr_q  <= link_len == 8'd0 || d2 > 61'(lim);
				zero_q <= d2 == 61'd0;
				if (xw_q >= 0) begin
					bx_q <= 32'(xw_q);
					by_q <= 32'(yw_q);
					bz_q <= '0;
				end else begin
					bx_q <= -32'(xw_q);
					by_q <= -32'(yw_q);
					bz_q <= (yw_q >= 0) ? HALF_TURN : -HALF_TURN;
				end
			end
			ST_SQRT: begin
				ax_q <= {6'd0, r_root};
				ay_q <= {6'd0, h_root};
				az_q <= '0;
			end
			ST_VEC: begin
				if (ay_q >= 0) begin
					ax_q <= ax_q + (ay_q >>> cnt_q);
					ay_q <= ay_q - (ax_q >>> cnt_q);
					az_q <= az_q + at;
				end else begin
					ax_q <= ax_q - (ay_q >>> cnt_q);
					ay_q <= ay_q + (ax_q >>> cnt_q);
					az_q <= az_q - at;
				end
				if (by_q >= 0) begin
					bx_q <= bx_q + (by_q >>> cnt_q);
					by_q <= by_q - (bx_q >>> cnt_q);
					bz_q <= bz_q + at;
				end else begin
					bx_q <= bx_q - (by_q >>> cnt_q);
					by_q <= by_q + (bx_q >>> cnt_q);
					bz_q <= bz_q - at;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					if (unr_q) begin
						j1_q <= job_q.current_joint1;
						j2_q <= job_q.current_joint2;
						j3_q <= 15'(job_q.current_joint3);
					end else begin
						j1_q <= 13'(round_tenths(a1));
						j2_q <= 13'(round_tenths(a2));
						j3_q <= 15'(round_tenths(a3));
					end
					unro_q <= unr_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			outv_q  <= 1'b0;
		end else begin
			if (res.ready) outv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (nempty) state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_WRIST;
				ST_WRIST: state_q <= ST_SQ;
				ST_SQ:    state_q <= ST_SUM;
				ST_SUM:   state_q <= sq_start ? ST_SQRT : ST_FIN;
				ST_SQRT: begin
					cnt_q <= '0;
					if (!r_busy && !h_busy) state_q <= ST_VEC;
				end
				ST_VEC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						outv_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid        = outv_q;
	assign res.joint1_angle = j1_q;
	assign res.joint2_angle = j2_q;
	assign res.joint3_angle = j3_q;
	assign res.unreachable  = unro_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_ROT) else $error("pop outside idle");
	a_cnt_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT || state_q == ST_VEC) |-> cnt_q < 5'(CORDIC_STEPS))
		else $error("cordic count overrun");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && !res.ready) |=> outv_q && $stable(j3_q))
		else $error("result overwritten while stalled");
	a_sqrt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !r_busy) else $error("square root restarted while busy");
endmodule
`default_nettype wire

/* rtl/core/planar_3r_inverse_kinematics.sv */
// Planar 3R inverse kinematics with three equal links. A command beat carries the
// gripper target (x, y in pixels with four fraction bits, phi in tenths of a degree),
// the elbow choice and the present joints; one result beat follows per command, in
// order, with the three joint angles rounded half up to 0.1 degree, or with the
// present joints and unreachable set when the wrist lies beyond twice the link.
// A reachable item passes through the back end in order: it is taken from the
// queue, the orientation CORDIC runs, the link products and the wrist radius are
// formed, the two integer square roots run side by side (26 steps, then the roots
// are collected), the two vectoring CORDICs also run side by side, and the result
// register is loaded; an unreachable item or one with the wrist on the base skips
// the square roots and the vectoring CORDICs. One iterative sequencer in the back
// end handles one item at a time. The front end and a two-entry queue take new
// commands while the back end works, and the result register lets the next item
// proceed while a result waits. Write the base and link registers only while idle.
`default_nettype none
module planar_3r_inverse_kinematics (
	input  logic     clk,
	input  logic     arst_n,
	ik_cfg_if.sink   cfg,
	ik_cmd_if.sink   cmd,
	ik_res_if.source res
);
	import ik_pkg::*;

	logic [9:0] base_x_q;
	logic [9:0] base_y_q;
	logic [7:0] link_q;

	ik_job_t  f_job;
	ik_job_t  q_job;
	ik_q_wr_t qwr;
	logic     q_nempty;
	logic     q_pop;

	// Configuration writes always complete; an index past the list is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= 10'd400;
			base_y_q <= 10'd400;
			link_q   <= 8'd50;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BASE_X: base_x_q <= cfg.data;
				REG_BASE_Y: base_y_q <= cfg.data;
				REG_LINK:   link_q   <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front: accept and fold the orientation into the CORDIC range.
	ik_front u_front (
		.cmd  (cmd),
		.full (qwr.full),
		.push (qwr.push),
		.job  (f_job)
	);

	// Hold decoded commands so front and back stall independently.
	ik_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qwr.push),
		.wdata  (f_job),
		.full   (qwr.full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_job)
	);

	// Back: sequence the solve and drive the result register.
	ik_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nempty   (q_nempty),
		.job      (q_job),
		.pop      (q_pop),
		.base_x   (base_x_q),
		.base_y   (base_y_q),
		.link_len (link_q),
		.res      (res)
	);
endmodule
`default_nettype wire
